[hdl/cssr_pkg.sv]
// Shared types and constants for cassette slope square recovery.
`timescale 1ns / 1ps

package cssr_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int DIFF_BITS   = SAMPLE_BITS + 1;
   localparam int THR_BITS    = 16;
   localparam int CFG_CNT_BITS = 12;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOPE_THRESHOLD = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTERVAL_MIN    = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTERVAL_MAX    = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEADER_RUN      = 4'd3;

   localparam logic [THR_BITS-1:0]     RESET_SLOPE_THRESHOLD = 16'd33;
   localparam logic [CFG_CNT_BITS-1:0] RESET_INTERVAL_MIN    = 12'd59;
   localparam logic [CFG_CNT_BITS-1:0] RESET_INTERVAL_MAX    = 12'd71;
   localparam logic [CFG_CNT_BITS-1:0] RESET_HEADER_RUN      = 12'd1020;

   typedef enum logic [1:0] {
      SLOPE_NONE = 2'd0,
      SLOPE_RISE = 2'd1,
      SLOPE_FALL = 2'd2
   } slope_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          restart;
   } req_word_type;

   typedef struct packed {
      logic level;
      logic edge_res;
      logic tone_found;
   } rsp_word_type;

   typedef struct packed {
      logic [THR_BITS-1:0]     slope_threshold;
      logic [CFG_CNT_BITS-1:0] interval_min;
      logic [CFG_CNT_BITS-1:0] interval_max;
      logic [CFG_CNT_BITS-1:0] header_run;
   } cfg_type;

endpackage

[hdl/cssr_step.sv]
// Next-state and result logic for one sample.
`timescale 1ns / 1ps

module cssr_step
   import cssr_pkg::*;
#(
   parameter int COUNT_BITS = 12
) (
   input  req_word_type                  word,
   input  cfg_type                       cfg,
   input  logic signed [SAMPLE_BITS-1:0] prev_sample,
   input  logic                          have_prev,
   input  slope_type                     last_slope,
   input  logic                          level,
   input  logic [COUNT_BITS-1:0]         since_toggle,
   input  logic [COUNT_BITS-1:0]         run_count,
   output logic signed [SAMPLE_BITS-1:0] prev_sample_in,
   output logic                          have_prev_in,
   output slope_type                     last_slope_in,
   output logic                          level_in,
   output logic [COUNT_BITS-1:0]         since_toggle_in,
   output logic [COUNT_BITS-1:0]         run_count_in,
   output rsp_word_type                  result
);

   localparam int CMP_BITS = (COUNT_BITS > CFG_CNT_BITS) ? COUNT_BITS : CFG_CNT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic                          cur_have;
   slope_type                     cur_slope;
   logic                          cur_level;
   logic [COUNT_BITS-1:0]         cur_since;
   logic [COUNT_BITS-1:0]         cur_run;
   logic signed [DIFF_BITS-1:0]   diff;
   logic [DIFF_BITS-1:0]          abs_diff;
   logic                          flat;
   slope_type                     slope;
   logic [COUNT_BITS-1:0]         since_inc;
   logic [COUNT_BITS-1:0]         run_inc;
   logic                          toggle;
   logic                          in_window;
   logic [CMP_BITS-1:0]           since_cmp;
   logic [CMP_BITS-1:0]           run_old_cmp;
   logic [CMP_BITS-1:0]           run_new_cmp;
   logic [CMP_BITS-1:0]           min_cmp;
   logic [CMP_BITS-1:0]           max_cmp;
   logic [CMP_BITS-1:0]           hr_cmp;

   // restart clears the history flag, slope, level and counters before the sample is looked at
   assign cur_have  = have_prev && !word.restart;
   assign cur_slope = word.restart ? SLOPE_NONE : last_slope;
   assign cur_level = level && !word.restart;
   assign cur_since = word.restart ? '0 : since_toggle;
   assign cur_run   = word.restart ? '0 : run_count;

   assign diff     = DIFF_BITS'(word.sample) - DIFF_BITS'(prev_sample);
   assign abs_diff = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
   assign flat     = abs_diff < DIFF_BITS'(cfg.slope_threshold);
   assign slope    = flat ? SLOPE_NONE :
                     (prev_sample < word.sample) ? SLOPE_RISE : SLOPE_FALL;

   assign since_inc = (cur_since == COUNT_MAX) ? cur_since : cur_since + 1'b1;
   assign run_inc   = (cur_run == COUNT_MAX) ? cur_run : cur_run + 1'b1;
   assign toggle    = cur_have && (slope != SLOPE_NONE) && (slope != cur_slope);

   assign since_cmp   = CMP_BITS'(since_inc);
   assign run_old_cmp = CMP_BITS'(cur_run);
   assign run_new_cmp = CMP_BITS'(run_inc);
   assign min_cmp     = CMP_BITS'(cfg.interval_min);
   assign max_cmp     = CMP_BITS'(cfg.interval_max);
   assign hr_cmp      = CMP_BITS'(cfg.header_run);
   assign in_window   = (min_cmp <= since_cmp) && (since_cmp <= max_cmp);

   always_comb begin
      prev_sample_in    = word.sample;
      have_prev_in      = 1'b1;
      last_slope_in     = cur_slope;
      level_in          = cur_level;
      since_toggle_in   = cur_since;
      run_count_in      = cur_run;
      result.edge_res   = 1'b0;
      result.tone_found = 1'b0;
      if (cur_have) begin
         since_toggle_in = since_inc;
         if (toggle) begin
            level_in        = !cur_level;
            last_slope_in   = slope;
            since_toggle_in = '0;
            result.edge_res = 1'b1;
            if (in_window) begin
               run_count_in      = run_inc;
               result.tone_found = (hr_cmp != '0) && (run_old_cmp < hr_cmp) &&
                                   (run_new_cmp >= hr_cmp);
            end else begin
               run_count_in = '0;
            end
         end
      end
      result.level = level_in;
   end

endmodule

[hdl/cassette_slope_square_recovery.sv]
// Top level: square-wave recovery and header-tone detection from tape samples.
//
//   port group | dir | word            | moves when
//   req_       | in  | sample, restart | req_valid && !req_stall
//   rsp_       | out | level, edge_res, tone_found | rsp_valid && !rsp_stall
//   csr_       | in  | index, data     | csr_write_enable
//
// One sample per cycle unless stalled; a result shows in the cycle after its sample.
// The slope, toggle and counter update is one pass of logic into the result register.
// Reset restores the register defaults and clears the recovery state; no sweep.
// req_stall follows rsp_stall only while a result is held in the output register.
`timescale 1ns / 1ps

module cassette_slope_square_recovery
   import cssr_pkg::*;
#(
   parameter int COUNT_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_word_type              req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_word_type              rsp_word,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   cfg_type                       cfg_ff;
   logic signed [SAMPLE_BITS-1:0] prev_sample_ff;
   logic                          have_prev_ff;
   slope_type                     last_slope_ff;
   logic                          level_ff;
   logic [COUNT_BITS-1:0]         since_toggle_ff;
   logic [COUNT_BITS-1:0]         run_count_ff;
   logic                          rsp_valid_ff;
   rsp_word_type                  rsp_word_ff;

   logic signed [SAMPLE_BITS-1:0] prev_sample_in;
   logic                          have_prev_in;
   slope_type                     last_slope_in;
   logic                          level_in;
   logic [COUNT_BITS-1:0]         since_toggle_in;
   logic [COUNT_BITS-1:0]         run_count_in;
   rsp_word_type                  rsp_word_in;
   logic                          accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   cssr_step #(
      .COUNT_BITS(COUNT_BITS)
   ) u_step (
      .word           (req_word),
      .cfg            (cfg_ff),
      .prev_sample    (prev_sample_ff),
      .have_prev      (have_prev_ff),
      .last_slope     (last_slope_ff),
      .level          (level_ff),
      .since_toggle   (since_toggle_ff),
      .run_count      (run_count_ff),
      .prev_sample_in (prev_sample_in),
      .have_prev_in   (have_prev_in),
      .last_slope_in  (last_slope_in),
      .level_in       (level_in),
      .since_toggle_in(since_toggle_in),
      .run_count_in   (run_count_in),
      .result         (rsp_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slope_threshold <= RESET_SLOPE_THRESHOLD;
         cfg_ff.interval_min    <= RESET_INTERVAL_MIN;
         cfg_ff.interval_max    <= RESET_INTERVAL_MAX;
         cfg_ff.header_run      <= RESET_HEADER_RUN;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SLOPE_THRESHOLD: cfg_ff.slope_threshold <= csr_data[THR_BITS-1:0];
            CSR_INTERVAL_MIN:    cfg_ff.interval_min    <= csr_data[CFG_CNT_BITS-1:0];
            CSR_INTERVAL_MAX:    cfg_ff.interval_max    <= csr_data[CFG_CNT_BITS-1:0];
            CSR_HEADER_RUN:      cfg_ff.header_run      <= csr_data[CFG_CNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sample_ff  <= '0;
         have_prev_ff    <= 1'b0;
         last_slope_ff   <= SLOPE_NONE;
         level_ff        <= 1'b0;
         since_toggle_ff <= '0;
         run_count_ff    <= '0;
      end else if (accept) begin
         prev_sample_ff  <= prev_sample_in;
         have_prev_ff    <= have_prev_in;
         last_slope_ff   <= last_slope_in;
         level_ff        <= level_in;
         since_toggle_ff <= since_toggle_in;
         run_count_ff    <= run_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result word needs no reset; it is loaded with every accepted sample
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule
